>>> src/assert_macros.svh
// Assertion helper macros for the slot allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSA_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BSA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int ADDR_W       = 48;
  localparam int OBJ_W        = 17;
  localparam int CNT_W        = 9;
  // stride is object size rounded up to 16, needs one extra bit
  localparam int STRIDE_W     = OBJ_W + 1;
  localparam int STRIDE_ALIGN = 16;
  // bitmap word width and its bit index width
  localparam int WORD_BITS    = 8;
  localparam int WBIT_W       = 3;

  // APB register map
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam logic [1:0] REG_BASE_ADDR = 2'd0;
  localparam logic [1:0] REG_OBJ_BYTES = 2'd1;
  localparam logic [1:0] REG_SLOT_CNT  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_FREED     = 2'd2,
    ST_NO_MATCH  = 2'd3
  } status_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    status_t           status;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/bsa_ifs.sv
// Valid/ready channel interfaces for request and result items
`timescale 1ns / 1ps
`default_nettype none

interface bsa_in_if;
  logic              valid;
  logic              ready;
  bsa_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsa_out_if;
  logic               valid;
  logic               ready;
  bsa_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/bitmap_slot_allocator.sv
// Top level: bitmap slot allocator with APB configuration
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size object pool manager. One used-bit per slot is kept in a small
// memory of 8-bit words. After reset a clearing pass writes one word per cycle
// over all (MAX_SLOTS+7)/8 words before the first item is taken. Requests are
// handled one at a time and the input is not ready while one is in progress.
// An allocate reads the bitmap a word at a time, reading then checking each
// word; a found slot goes through one multiply and one add for base + slot *
// stride, then the result register, and a scan that finds no free slot
// reports pool full. A free checks the address against the pool limit with
// the same multiplier, then, when the stride is nonzero, divides the offset by
// the stride in an iterative divider that produces one slot-index bit per
// cycle; a free that misses answers sooner than one that hits a slot. The
// result sits in an output register; a new request is taken while it waits,
// and that request holds in its last step until the waiting result is taken.
// stride = object_bytes rounded up to 16; all address arithmetic wraps at 2^48.

`include "assert_macros.svh"

module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bsa_in_if.sink                            in_ch,
  bsa_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bsa_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bsa_pkg::CFG_DW-1:0]   pwdata,
  output logic      [bsa_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int WB     = bsa_pkg::WORD_BITS;
  localparam int NWORDS = (MAX_SLOTS + WB - 1) / WB;
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SW     = WAW + bsa_pkg::WBIT_W;
  localparam int NW     = $clog2(MAX_SLOTS + 1);
  localparam int PW     = SW + 1 + bsa_pkg::STRIDE_W;
  localparam int AW     = bsa_pkg::ADDR_W;
  localparam int STW    = bsa_pkg::STRIDE_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_MUL, S_A_ADD,
    S_F_CMP, S_DIV, S_F_RD, S_F_WR, S_DONE
  } state_t;

  // configuration registers
  logic [AW-1:0]                 base_r;
  logic [bsa_pkg::OBJ_W-1:0]     obj_r;
  logic [bsa_pkg::CNT_W-1:0]     slot_cnt_r;

  // request context
  state_t                        state_r;
  logic                          op_r;
  logic [AW-1:0]                 diff_r;
  logic [NW-1:0]                 n_r;
  logic [STW-1:0]                stride_r;
  logic [WAW-1:0]                word_r;
  logic [SW-1:0]                 slot_r;
  logic [PW-1:0]                 prod_r;
  logic [AW-1:0]                 res_addr_r;
  bsa_pkg::status_t              res_status_r;

  // output register
  logic                          out_valid_r;
  logic [AW-1:0]                 out_addr_r;
  bsa_pkg::status_t              out_status_r;

  // bitmap memory
  logic [WB-1:0]                 mem_r [NWORDS];
  logic [WB-1:0]                 rd_data_r;
  logic                          mem_we;
  logic [WB-1:0]                 mem_wdata;

  logic                          cfg_wr;
  logic                          in_acc;
  logic [NW-1:0]                 n_w;
  logic [STW-1:0]                stride_w;
  logic [WB-1:0]                 avail;
  logic                          found;
  logic [bsa_pkg::WBIT_W-1:0]    fb;
  logic                          last_word;
  logic [SW:0]                   mul_a;
  logic                          div_start;
  logic                          div_done;
  logic [SW-1:0]                 div_q;
  logic                          div_rem_zero;

  // APB port: writes land on the access phase, reads are combinational
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      obj_r      <= bsa_pkg::OBJ_W'(16);
      slot_cnt_r <= bsa_pkg::CNT_W'(256);
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        bsa_pkg::REG_BASE_ADDR: base_r     <= pwdata[AW-1:0];
        bsa_pkg::REG_OBJ_BYTES: obj_r      <= pwdata[bsa_pkg::OBJ_W-1:0];
        bsa_pkg::REG_SLOT_CNT:  slot_cnt_r <= pwdata[bsa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      bsa_pkg::REG_BASE_ADDR: prdata = bsa_pkg::CFG_DW'(base_r);
      bsa_pkg::REG_OBJ_BYTES: prdata = bsa_pkg::CFG_DW'(obj_r);
      bsa_pkg::REG_SLOT_CNT:  prdata = bsa_pkg::CFG_DW'(slot_cnt_r);
      default:                prdata = '0;
    endcase
  end

  // effective slot count and stride
  assign n_w = (32'(slot_cnt_r) > MAX_SLOTS) ? NW'(MAX_SLOTS) : NW'(slot_cnt_r);
  assign stride_w = (STW'(obj_r) + STW'(bsa_pkg::STRIDE_ALIGN - 1))
                  & ~STW'(bsa_pkg::STRIDE_ALIGN - 1);

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // free slots in the current word, restricted to slots below the count
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      avail[b] = !rd_data_r[b]
              && ((SW + 1)'({word_r, bsa_pkg::WBIT_W'(b)}) < (SW + 1)'(n_r));
    end
  end

  // lowest free bit
  always_comb begin
    found = 1'b0;
    fb    = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found = 1'b1;
        fb    = bsa_pkg::WBIT_W'(b);
      end
    end
  end

  assign last_word = ((32'(word_r) + 32'd1) * WB) >= 32'(n_r);

  // shared multiplier operand: slot index on allocate, slot count on free
  assign mul_a = (op_r == bsa_pkg::OP_FREE) ? (SW + 1)'(n_r) : (SW + 1)'(slot_r);

  // bitmap write port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_A_CHK: begin
        mem_we    = found;
        mem_wdata = rd_data_r | (WB'(1) << fb);
      end
      S_F_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r & ~(WB'(1) << slot_r[bsa_pkg::WBIT_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[word_r] <= mem_wdata;
    end
    rd_data_r <= mem_r[word_r];
  end

  // offset below limit was checked, so it fits the divider width
  assign div_start = (state_r == S_F_CMP) && (stride_r != '0)
                  && (diff_r < AW'(prod_r));

  bsa_divider #(
    .SW (SW),
    .RW (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_r[PW-1:0]),
    .divisor  (stride_r),
    .done     (div_done),
    .quotient (div_q),
    .rem_zero (div_rem_zero)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: refilled from the last step, else drained by the receiver
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= res_addr_r;
        out_status_r <= res_status_r;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (word_r == WAW'(NWORDS - 1)) begin
            word_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_ch.data.op;
            diff_r   <= in_ch.data.free_address - base_r;
            n_r      <= n_w;
            stride_r <= stride_w;
            word_r   <= '0;
            if (in_ch.data.op == bsa_pkg::OP_FREE) begin
              state_r <= S_MUL;
            end else if (n_w == '0) begin
              res_addr_r   <= '0;
              res_status_r <= bsa_pkg::ST_POOL_FULL;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_A_RD;
            end
          end
        end
        S_A_RD: begin
          state_r <= S_A_CHK;
        end
        S_A_CHK: begin
          if (found) begin
            slot_r  <= {word_r, fb};
            state_r <= S_MUL;
          end else if (last_word) begin
            res_addr_r   <= '0;
            res_status_r <= bsa_pkg::ST_POOL_FULL;
            state_r      <= S_DONE;
          end else begin
            word_r  <= word_r + 1'b1;
            state_r <= S_A_RD;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(mul_a) * PW'(stride_r);
          state_r <= (op_r == bsa_pkg::OP_FREE) ? S_F_CMP : S_A_ADD;
        end
        S_A_ADD: begin
          res_addr_r   <= base_r + AW'(prod_r);
          res_status_r <= bsa_pkg::ST_ALLOCATED;
          state_r      <= S_DONE;
        end
        S_F_CMP: begin
          if (stride_r == '0) begin
            // zero stride: every slot sits at base, slot zero wins
            if (diff_r == '0 && n_r != '0) begin
              slot_r  <= '0;
              word_r  <= '0;
              state_r <= S_F_RD;
            end else begin
              res_addr_r   <= '0;
              res_status_r <= bsa_pkg::ST_NO_MATCH;
              state_r      <= S_DONE;
            end
          end else if (div_start) begin
            state_r <= S_DIV;
          end else begin
            res_addr_r   <= '0;
            res_status_r <= bsa_pkg::ST_NO_MATCH;
            state_r      <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_rem_zero) begin
              slot_r  <= div_q;
              word_r  <= div_q[SW-1:bsa_pkg::WBIT_W];
              state_r <= S_F_RD;
            end else begin
              res_addr_r   <= '0;
              res_status_r <= bsa_pkg::ST_NO_MATCH;
              state_r      <= S_DONE;
            end
          end
        end
        S_F_RD: begin
          state_r <= S_F_WR;
        end
        S_F_WR: begin
          res_addr_r   <= '0;
          res_status_r <= bsa_pkg::ST_FREED;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.data.granted_address = out_addr_r;
  assign out_ch.data.status          = out_status_r;

  // checks
  `BSA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ch.ready,
    "block still ready right after taking an item")
  `BSA_ASSERT_NOW(a_no_write_idle, clk, rst_n, state_r == S_IDLE, !mem_we,
    "bitmap written while idle")
  `BSA_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_done, state_r == S_DIV,
    "divider finished outside the divide step")
  `BSA_ASSERT_NOW(a_addr_zero, clk, rst_n,
    out_valid_r && out_status_r != bsa_pkg::ST_ALLOCATED, out_addr_r == '0,
    "nonzero address on a result that is not a grant")

endmodule

`default_nettype wire

>>> src/bsa_divider.sv
// Iterative restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bsa_divider #(
  parameter int SW = 8,   // quotient width
  parameter int RW = 27   // dividend / remainder width
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [RW-1:0]                 dividend,
  input  wire logic [bsa_pkg::STRIDE_W-1:0]  divisor,
  output logic                               done,
  output logic [SW-1:0]                      quotient,
  output logic                               rem_zero
);

  localparam int CW = $clog2(SW);

  logic [RW-1:0] rem_r;
  logic [RW-1:0] dv_r;
  logic [SW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  // dividend is known to be below divisor * 2^SW, so SW steps suffice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        dv_r   <= RW'(divisor) << (SW - 1);
        q_r    <= '0;
        cnt_r  <= CW'(SW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_r >= dv_r) begin
          rem_r <= rem_r - dv_r;
          q_r   <= {q_r[SW-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[SW-2:0], 1'b0};
        end
        dv_r <= dv_r >> 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
  assign rem_zero = (rem_r == '0);

endmodule

`default_nettype wire
